// ===== sv/binary_max_heap_priority_queue_macros.svh =====
// Assertion macros for the binary max-heap priority queue.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every edge outside reset
`define BMHPQ_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define BMHPQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMHPQ_ASSERT(name, clk, rstn, prop, msg)
`define BMHPQ_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== sv/bmhpq_pkg.sv =====
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; imported by bmhpq_ram, binary_max_heap_priority_queue and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package bmhpq_pkg;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 9;
  localparam int unsigned LimitW    = 9;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 48;

  localparam logic [LimitW-1:0] LimitReset = 9'd256;

  typedef enum logic [ModeW-1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_LOOK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPACITY_LIMIT = 1'b0,
    CFG_COMPARE_SIGNED = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TOP  = 5'b00010,
    S_UP   = 5'b00100,
    S_DOWN = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== sv/bmhpq_ram.sv =====
// Heap key store: one write port, two read ports, registered read data.
// Uses bmhpq_pkg; instantiated by binary_max_heap_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module bmhpq_ram
  import bmhpq_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== sv/binary_max_heap_priority_queue.sv =====
// Binary max-heap priority queue: control, sift sequencer and output stage.
// Uses bmhpq_pkg, bmhpq_ram and binary_max_heap_priority_queue_macros.svh.
//
// Usage: one operation per transfer on the slave stream (tuser = mode,
// tdata = key); exactly one result per operation on the master stream.
// Configuration writes (capacity limit, signed compare) go through
// cfg_we_i/cfg_index_i/cfg_data_i; the user must issue them only while the
// queue is idle, as the block itself does not enforce it. Full insert,
// clear, and get/look on an empty queue go from accept straight to the
// output stage; look reads the root, then outputs; insert sifts the key up
// with one heap-store read, compare and write-back per level it rises; get
// reads the root and last entry, moves that entry to the root and sinks it
// level by level the same way (straight to output if it was the last).
// One operation is in flight at a time; the next is accepted once the
// previous result sits in the output register, even if it is not yet taken.
// Reset empties the queue, sets the limit to 256 and unsigned compare; no
// clearing pass is needed. A stalled receiver holds the result in the
// output register; a finished operation then waits until it drains.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_max_heap_priority_queue_macros.svh"

module binary_max_heap_priority_queue
  import bmhpq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // operation stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [31:0] new_value
  input  wire logic [ModeW-1:0]    s_axis_tuser,  // [1:0] mode
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata   // [31:0] top_value,
                                                  // [33:32] status,
                                                  // [42:34] count_after
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned PadW = OutDataW - ValueW - StatusW - CountOutW;

  function automatic logic key_above(input logic [KEY_WIDTH-1:0] a,
                                     input logic [KEY_WIDTH-1:0] b,
                                     input logic sgn);
    logic [KEY_WIDTH-1:0] flip;
    flip = KEY_WIDTH'(sgn) << (KEY_WIDTH - 1);
    return (a ^ flip) > (b ^ flip);
  endfunction

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW-1:0] pm1;
    pm1 = p - 1'b1;
    return pm1 >> 1;
  endfunction

  function automatic logic [IW-1:0] left_of(input logic [AW-1:0] p);
    return IW'({p, 1'b1});
  endfunction

  // ---------------------------------------------------------------------
  // registers
  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [KEY_WIDTH-1:0] val_q, val_d;
  logic [KEY_WIDTH-1:0] top_q, top_d;
  status_e              status_q, status_d;
  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_data_q, m_data_d;
  logic [LimitW-1:0]    limit_q;
  logic                 signed_q;

  // memory ports
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr_a, mem_raddr_b;
  logic [KEY_WIDTH-1:0] mem_rdata_a, mem_rdata_b;

  // datapath helpers
  logic [63:0]          nv_ext;
  logic [KEY_WIDTH-1:0] in_key;
  op_e                  in_op;
  logic                 in_full;
  logic [CW-1:0]        count_m1;
  logic [IW-1:0]        left_idx, right_idx;
  logic                 left_ok, right_ok;
  logic                 r_above_v, r_above_l, l_above_v;
  logic                 move_r, move_l;
  logic [63:0]          top_ext;
  logic                 accept;

  assign nv_ext    = {32'b0, s_axis_tdata};
  assign in_key    = nv_ext[KEY_WIDTH-1:0];
  assign in_op     = op_e'(s_axis_tuser);
  assign in_full   = (32'(count_q) >= 32'(limit_q)) || (32'(count_q) >= CAPACITY);
  assign count_m1  = count_q - 1'b1;
  assign left_idx  = left_of(pos_q);
  assign right_idx = left_idx + 1'b1;
  assign left_ok   = 32'(left_idx) < 32'(count_q);
  assign right_ok  = 32'(right_idx) < 32'(count_q);
  assign r_above_v = key_above(mem_rdata_b, val_q, signed_q);
  assign r_above_l = key_above(mem_rdata_b, mem_rdata_a, signed_q);
  assign l_above_v = key_above(mem_rdata_a, val_q, signed_q);
  // left wins ties between equal children
  assign move_r    = right_ok && r_above_v && r_above_l;
  assign move_l    = (right_ok && r_above_v && !r_above_l) ||
                     (!(right_ok && r_above_v) && left_ok && l_above_v);
  assign top_ext   = 64'(top_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  bmhpq_ram #(
    .Depth (CAPACITY),
    .Width (KEY_WIDTH),
    .AddrW (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    top_d       = top_q;
    status_d    = status_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = val_q;
    mem_raddr_a = '0;
    mem_raddr_b = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = in_op;
          top_d    = '0;
          status_d = ST_OK;
          unique case (in_op)
            OP_INSERT: begin
              if (in_full) begin
                status_d = ST_FULL;
                state_d  = S_OUT;
              end else begin
                val_d       = in_key;
                pos_d       = count_q[AW-1:0];
                count_d     = count_q + 1'b1;
                mem_raddr_a = parent_of(count_q[AW-1:0]);
                state_d     = S_UP;
              end
            end
            OP_GET, OP_LOOK: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_OUT;
              end else begin
                mem_raddr_a = '0;
                mem_raddr_b = count_m1[AW-1:0];
                if (in_op == OP_GET) begin
                  count_d = count_m1;
                end
                state_d = S_TOP;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_TOP: begin
        top_d = mem_rdata_a;
        if (op_q == OP_LOOK) begin
          state_d = S_OUT;
        end else begin
          // last entry moves to the root and sinks
          val_d       = mem_rdata_b;
          pos_d       = '0;
          mem_raddr_a = AW'(left_of('0));
          mem_raddr_b = AW'(left_of('0) + 1'b1);
          state_d     = (count_q == '0) ? S_OUT : S_DOWN;
        end
      end

      S_UP: begin
        mem_we = 1'b1;
        if (pos_q != '0 && key_above(val_q, mem_rdata_a, signed_q)) begin
          // parent drops into the hole, hole climbs
          mem_wdata   = mem_rdata_a;
          pos_d       = parent_of(pos_q);
          mem_raddr_a = parent_of(parent_of(pos_q));
        end else begin
          state_d = S_OUT;
        end
      end

      S_DOWN: begin
        mem_we = 1'b1;
        if (move_r) begin
          mem_wdata   = mem_rdata_b;
          pos_d       = right_idx[AW-1:0];
          mem_raddr_a = AW'(left_of(right_idx[AW-1:0]));
          mem_raddr_b = AW'(left_of(right_idx[AW-1:0]) + 1'b1);
        end else if (move_l) begin
          mem_wdata   = mem_rdata_a;
          pos_d       = left_idx[AW-1:0];
          mem_raddr_a = AW'(left_of(left_idx[AW-1:0]));
          mem_raddr_b = AW'(left_of(left_idx[AW-1:0]) + 1'b1);
        end else begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {PadW'(0), CountOutW'(count_q), status_q, top_ext[ValueW-1:0]};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      limit_q   <= LimitReset;
      signed_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_CAPACITY_LIMIT: limit_q  <= cfg_data_i[LimitW-1:0];
          CFG_COMPARE_SIGNED: signed_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    top_q    <= top_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
  end

  // ---------------------------------------------------------------------
  // checks
  `BMHPQ_ASSERT(count_in_range_a, clk_i, rst_ni, 32'(count_q) <= CAPACITY, "count above capacity")
  `BMHPQ_ASSERT(write_below_count_a, clk_i, rst_ni, mem_we |-> 32'(mem_waddr) < 32'(count_q), "heap write outside held entries")
  `BMHPQ_ASSERT(get_decrements_a, clk_i, rst_ni, (accept && in_op == OP_GET && count_q != '0) |=> count_q == $past(count_q) - 1'b1, "get did not remove one entry")
  `BMHPQ_ASSERT(insert_increments_a, clk_i, rst_ni, (accept && in_op == OP_INSERT && !in_full) |=> count_q == $past(count_q) + 1'b1, "insert did not add one entry")
  `BMHPQ_ASSERT_ALWAYS(reset_quiet_a, clk_i, !rst_ni |=> (!m_axis_tvalid && s_axis_tready), "outputs not quiet in reset")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for binary_max_heap_priority_queue: keeps its own heap of
// expected contents, drives operations on the slave stream and checks every result.
// Depends on bmhpq_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
  import bmhpq_pkg::*;

  localparam int unsigned HeapDepth  = 256;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [ValueW-1:0]    top;
    status_e              status;
    logic [CountOutW-1:0] count;
  } pq_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;   // [31:0] new_value
  logic [ModeW-1:0]     s_axis_tuser = '0;   // [1:0] mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;        // [31:0] top_value, [33:32] status,
                                             // [42:34] count_after

  // expected heap contents and register copies
  logic [ValueW-1:0] heap_keys [HeapDepth];
  int unsigned       heap_count = 0;
  int unsigned       limit_reg = LimitReset;
  bit                signed_cmp = 1'b0;

  pq_result_t  pending_results [$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned ops_sent = 0;
  int unsigned results_seen = 0;
  int unsigned n_ok = 0, n_full = 0, n_empty = 0;
  int unsigned max_depth = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  binary_max_heap_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("binary_max_heap_priority_queue regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------
  function automatic bit ranks_above(logic [ValueW-1:0] a, logic [ValueW-1:0] b);
    if (signed_cmp) return $signed(a) > $signed(b);
    return a > b;
  endfunction

  function automatic void swap_keys(int unsigned i, int unsigned j);
    logic [ValueW-1:0] t;
    t = heap_keys[i];
    heap_keys[i] = heap_keys[j];
    heap_keys[j] = t;
  endfunction

  function automatic pq_result_t apply_heap_op(op_e op, logic [ValueW-1:0] key);
    pq_result_t  r;
    int unsigned eff_limit, pos, parent, left, right, pick;
    r.top = '0;
    r.status = ST_OK;
    eff_limit = (limit_reg > HeapDepth) ? HeapDepth : limit_reg;
    case (op)
      OP_INSERT: begin
        if (heap_count >= eff_limit) begin
          r.status = ST_FULL;
        end else begin
          heap_keys[heap_count] = key;
          pos = heap_count;
          heap_count++;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!ranks_above(heap_keys[pos], heap_keys[parent])) break;
            swap_keys(pos, parent);
            pos = parent;
          end
        end
      end
      OP_GET: begin
        if (heap_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top = heap_keys[0];
          heap_count--;
          heap_keys[0] = heap_keys[heap_count];
          pos = 0;
          while (1) begin
            left = 2 * pos + 1;
            right = left + 1;
            pick = pos;
            // ties between children go left; a child equal to its parent stays
            if (right < heap_count && ranks_above(heap_keys[right], heap_keys[pos]))
              pick = ranks_above(heap_keys[right], heap_keys[left]) ? right : left;
            else if (left < heap_count && ranks_above(heap_keys[left], heap_keys[pos]))
              pick = left;
            if (pick == pos) break;
            swap_keys(pos, pick);
            pos = pick;
          end
        end
      end
      OP_LOOK: begin
        if (heap_count == 0) r.status = ST_EMPTY;
        else r.top = heap_keys[0];
      end
      default: heap_count = 0;
    endcase
    if (heap_count > max_depth) max_depth = heap_count;
    r.count = heap_count[CountOutW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_op(op_e op, logic [ValueW-1:0] key);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= key;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_heap_op(op, key));
    ops_sent++;
  endtask

  // sender stops and waits for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_CAPACITY_LIMIT: limit_reg = value;
      default:            signed_cmp = value[0];
    endcase
  endtask

  task automatic set_config(int unsigned limit, bit use_signed);
    wait_drained();
    write_reg(CFG_CAPACITY_LIMIT, limit[CfgDataW-1:0]);
    write_reg(CFG_COMPARE_SIGNED, CfgDataW'(use_signed));
  endtask

  function automatic logic [ValueW-1:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(15);  // many duplicates
      2: return ($urandom_range(1) ? 32'h7FFF_FFF8 : 32'hFFFF_FFF8) + $urandom_range(15);
      default: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic report_failure(string msg);
    failures++;
    if (failures <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : result_check
    pq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result 0x%h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        case (want.status)
          ST_OK:   n_ok++;
          ST_FULL: n_full++;
          default: n_empty++;
        endcase
        if (m_axis_tdata[31:0] !== want.top)
          report_failure($sformatf("top_value exp 0x%h got 0x%h",
                                   want.top, m_axis_tdata[31:0]));
        if (m_axis_tdata[33:32] !== want.status)
          report_failure($sformatf("status exp %0d got %0d",
                                   want.status, m_axis_tdata[33:32]));
        if (m_axis_tdata[42:34] !== want.count)
          report_failure($sformatf("count_after exp %0d got %0d",
                                   want.count, m_axis_tdata[42:34]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_edges();
    send_op(OP_GET, 32'h1234_5678);   // empty queue
    send_op(OP_LOOK, '0);
    send_op(OP_INSERT, 32'h0000_0000);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_LOOK, '0);
    send_op(OP_GET, '0);
    send_op(OP_CLEAR, 32'hFFFF_FFFF);
    send_op(OP_LOOK, '0);
  endtask

  task automatic test_capacity_limits();
    set_config(0, 1'b0);              // every insert full
    send_op(OP_INSERT, 32'h0000_0055);
    set_config(1, 1'b0);
    send_op(OP_INSERT, 32'h0000_00AA);
    send_op(OP_INSERT, 32'h0000_00BB);
    set_config(256, 1'b0);
    send_op(OP_INSERT, 32'h0000_0010);
    send_op(OP_INSERT, 32'h0000_0030);
    send_op(OP_INSERT, 32'h0000_0020);
    set_config(2, 1'b0);              // limit now below the held count
    send_op(OP_INSERT, 32'h0000_0040);
    send_op(OP_GET, '0);
  endtask

  task automatic test_signed_order();
    set_config(256, 1'b1);
    send_op(OP_CLEAR, '0);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    repeat (3) send_op(OP_GET, '0);
  endtask

  // fill to the hard capacity and past it, then drain past empty
  task automatic test_fill_to_capacity();
    set_config(256, $urandom_range(1));
    send_op(OP_CLEAR, '0);
    repeat (HeapDepth + 2) send_op(OP_INSERT, rand_key());
    repeat (HeapDepth + 2) send_op(OP_GET, rand_key());
  endtask

  task automatic test_random_mix(int unsigned n_ops);
    int unsigned burst_left, r;
    bit          filling;
    op_e         op;
    burst_left = 0;
    filling = 1'b1;
    repeat (n_ops) begin
      if (burst_left == 0) begin
        filling = $urandom_range(1);
        burst_left = $urandom_range(60, 8);
      end
      burst_left--;
      r = $urandom_range(99);
      if (r < 1)                        op = OP_CLEAR;
      else if (r < 11)                  op = OP_LOOK;
      else if (r < (filling ? 81 : 26)) op = OP_INSERT;
      else                              op = OP_GET;
      send_op(op, rand_key());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_capacity_limits();
    test_signed_order();

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  set_config(511, 1'b0); end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  set_config(256, 1'b1); end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 51;
          set_config($urandom_range(40, 1), $urandom_range(1));
        end
        default: begin
          send_idle_pct = 24; recv_stall_pct = 24;
          set_config($urandom_range(255, 2), $urandom_range(1));
        end
      endcase
      test_random_mix(80);
      wait_drained();                 // sender holds off until all results are in
      test_random_mix(80);
      if (phase == 3) test_fill_to_capacity();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d operations, %0d results: %0d ok, %0d full, %0d empty",
             ops_sent, results_seen, n_ok, n_full, n_empty);
    $display("deepest heap %0d entries; limits 0 to 511, both compare modes, %0d failures",
             max_depth, failures);
    if (failures == 0) begin
      $display("binary_max_heap_priority_queue regression: pass");
    end else begin
      $display("binary_max_heap_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

// ===== binary_max_heap_priority_queue.f =====
+incdir+sv
sv/bmhpq_pkg.sv
sv/bmhpq_ram.sv
sv/binary_max_heap_priority_queue.sv
tb/sv/tb_top.sv
